[rtl/kmc_pkg.sv]
// Shared types and constants of the k-nearest-neighbor classifier.
package kmc_pkg;

	// Input commands
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_K_NEIGHBORS    = 2'd0;
	localparam logic [1:0] CFG_GOOD_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_FAIR_THRESHOLD = 2'd2;

	// Configuration reset values
	localparam logic [4:0] K_RESET         = 5'd3;
	localparam logic [6:0] GOOD_THR_RESET  = 7'd70;
	localparam logic [6:0] FAIR_THR_RESET  = 7'd60;

	// Verdict codes
	localparam logic [1:0] VERDICT_GOOD = 2'd0;
	localparam logic [1:0] VERDICT_FAIR = 2'd1;
	localparam logic [1:0] VERDICT_POOR = 2'd2;
	localparam logic [1:0] VERDICT_NONE = 2'd3;

	// Field widths
	localparam int SCORE_W = 7;
	localparam int DIST_W  = 9;
	localparam int VOTE_W  = 5;
	localparam int ENTRY_W = 3 * SCORE_W;

	// Largest K the 5-bit register can ask for
	localparam int K_MAX = 31;

	typedef enum logic [1:0] {
		LBL_GOOD = 2'd0,
		LBL_FAIR = 2'd1,
		LBL_POOR = 2'd2
	} label_t;

	// Request from the distance pipeline into the neighbor list
	typedef struct packed {
		logic              clear;
		logic              insert;
		logic [DIST_W-1:0] distance;
		label_t            label;
	} ins_req_t;

endpackage

[rtl/kmc_ram.sv]
// Generic single-port-write, registered-read RAM.
module kmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/kmc_nbr_list.sv]
// Sorted list of the nearest neighbors seen so far, filled by insertion.
module kmc_nbr_list #(
	parameter int SLOTS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  kmc_pkg::ins_req_t                    req,
	input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_slot,
	output kmc_pkg::label_t                      rd_label
);

	logic [SLOTS-1:0]               valid_q;
	logic [kmc_pkg::DIST_W-1:0]     dist_q  [SLOTS];
	kmc_pkg::label_t                label_q [SLOTS];

	logic [SLOTS-1:0] gt;
	logic [SLOTS-1:0] prev_gt;

	// A slot lies behind the new entry when empty or strictly farther;
	// equal distances keep the earlier arrival in front
	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			gt[s] = !valid_q[s] || (dist_q[s] > req.distance);
		end
		prev_gt = gt << 1;
	end

	// Valid bits: insert at the first farther slot, shift the tail down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.insert) begin
			if (gt[0]) begin
				valid_q[0] <= 1'b1;
			end
			for (int s = 1; s < SLOTS; s++) begin
				if (gt[s] && !prev_gt[s]) begin
					valid_q[s] <= 1'b1;
				end else if (gt[s]) begin
					valid_q[s] <= valid_q[s-1];
				end
			end
		end
	end

	// Payload of the slots
	always_ff @(posedge clk) begin
		if (req.insert) begin
			if (gt[0]) begin
				dist_q[0]  <= req.distance;
				label_q[0] <= req.label;
			end
			for (int s = 1; s < SLOTS; s++) begin
				if (gt[s] && !prev_gt[s]) begin
					dist_q[s]  <= req.distance;
					label_q[s] <= req.label;
				end else if (gt[s]) begin
					dist_q[s]  <= dist_q[s-1];
					label_q[s] <= label_q[s-1];
				end
			end
		end
	end

	assign rd_label = label_q[rd_slot];

endmodule

[rtl/knn_manhattan_classifier.sv]
// K-nearest-neighbor classifier: Manhattan distance over three scores, majority vote.
// Clear and add complete on acceptance and leave the block idle. A query with N stored
// references and effective K reads the N RAM entries one per cycle, then tallies one
// neighbor slot per cycle; the next transaction is taken in the cycle after the result
// is loaded, later while an older result still waits.
// Reset (arst_n low) empties the store and restores K=3, thresholds 70 and 60.
module knn_manhattan_classifier #(
	parameter int MAX_REFS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [6:0] score_first,
	input  logic [6:0] score_second,
	input  logic [6:0] score_third,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] verdict,
	output logic [4:0] good_votes,
	output logic [4:0] fair_votes,
	output logic [4:0] poor_votes,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);

	localparam int IDX_W  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
	localparam int CNT_W  = $clog2(MAX_REFS + 1);
	localparam int SLOTS  = (MAX_REFS < kmc_pkg::K_MAX) ? MAX_REFS : kmc_pkg::K_MAX;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CMP_W  = (CNT_W > kmc_pkg::VOTE_W) ? CNT_W : kmc_pkg::VOTE_W;
	localparam int SW     = kmc_pkg::SCORE_W;
	localparam int DW     = kmc_pkg::DIST_W;
	localparam int VW     = kmc_pkg::VOTE_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_TALLY,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [4:0] k_q;
	logic [6:0] good_thr_q;
	logic [6:0] fair_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= kmc_pkg::K_RESET;
			good_thr_q <= kmc_pkg::GOOD_THR_RESET;
			fair_thr_q <= kmc_pkg::FAIR_THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kmc_pkg::CFG_K_NEIGHBORS:    k_q        <= cfg_data[4:0];
				kmc_pkg::CFG_GOOD_THRESHOLD: good_thr_q <= cfg_data;
				kmc_pkg::CFG_FAIR_THRESHOLD: fair_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [SW-1:0]    q0_q, q1_q, q2_q;
	logic [VW-1:0]    keff_q;
	logic [VW-1:0]    tally_q;
	logic [VW-1:0]    good_cnt_q, fair_cnt_q, poor_cnt_q;
	logic             out_valid_q;
	logic [1:0]       verdict_q;
	logic [VW-1:0]    good_out_q, fair_out_q, poor_out_q;

	logic rd_vld_s1;
	logic vld_s2;
	logic [DW-1:0] dist_s2;
	logic [DW-1:0] sum_s2;

	// Accept side
	logic in_acc;
	logic is_query;
	logic store_full;
	logic ram_we;
	assign in_ready   = (state_q == S_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign is_query   = in_acc && (command == kmc_pkg::CMD_QUERY);
	assign store_full = (count_q >= CNT_W'(MAX_REFS));
	assign ram_we     = in_acc && (command == kmc_pkg::CMD_ADD) && !store_full;

	// Effective K: never more than the stored references
	logic [CMP_W-1:0] k_ext, cnt_ext;
	logic [VW-1:0]    keff_d;
	always_comb begin
		k_ext   = CMP_W'(k_q);
		cnt_ext = CMP_W'(count_q);
		keff_d  = (k_ext < cnt_ext) ? k_q : VW'(count_q);
	end

	// Reference RAM
	logic            issue;
	logic [kmc_pkg::ENTRY_W-1:0] rdata;
	assign issue = (state_q == S_READ) && (rd_idx_q < count_q);

	kmc_ram #(
		.WIDTH(kmc_pkg::ENTRY_W),
		.DEPTH(MAX_REFS)
	) u_ref_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({score_first, score_second, score_third}),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	// Stage 1: distance and score sum of the entry just read
	logic [SW-1:0] r0, r1, r2, d0, d1, d2;
	logic [DW-1:0] dist_d, sum_d;
	always_comb begin
		r0 = rdata[3*SW-1:2*SW];
		r1 = rdata[2*SW-1:SW];
		r2 = rdata[SW-1:0];
		d0 = (q0_q > r0) ? (q0_q - r0) : (r0 - q0_q);
		d1 = (q1_q > r1) ? (q1_q - r1) : (r1 - q1_q);
		d2 = (q2_q > r2) ? (q2_q - r2) : (r2 - q2_q);
		dist_d = DW'(d0) + DW'(d1) + DW'(d2);
		sum_d  = DW'(r0) + DW'(r1) + DW'(r2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dist_s2 <= dist_d;
		sum_s2  <= sum_d;
	end

	// Stage 2: label by floor mean; mean > t exactly when sum >= 3t + 3
	logic [DW-1:0]     good_lim, fair_lim;
	kmc_pkg::label_t   label_s2;
	always_comb begin
		good_lim = (DW'(good_thr_q) << 1) + DW'(good_thr_q) + DW'(3);
		fair_lim = (DW'(fair_thr_q) << 1) + DW'(fair_thr_q) + DW'(3);
		if (sum_s2 >= good_lim) begin
			label_s2 = kmc_pkg::LBL_GOOD;
		end else if (sum_s2 >= fair_lim) begin
			label_s2 = kmc_pkg::LBL_FAIR;
		end else begin
			label_s2 = kmc_pkg::LBL_POOR;
		end
	end

	// Neighbor list
	kmc_pkg::ins_req_t ins_req;
	kmc_pkg::label_t   slot_label;
	always_comb begin
		ins_req.clear    = is_query;
		ins_req.insert   = vld_s2;
		ins_req.distance = dist_s2;
		ins_req.label    = label_s2;
	end

	kmc_nbr_list #(
		.SLOTS(SLOTS)
	) u_nbr_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ins_req),
		.rd_slot (tally_q[SLOT_W-1:0]),
		.rd_label(slot_label)
	);

	// Strict-majority verdict from the tallied counts
	logic [1:0] verdict_d;
	always_comb begin
		if (good_cnt_q > fair_cnt_q && good_cnt_q > poor_cnt_q) begin
			verdict_d = kmc_pkg::VERDICT_GOOD;
		end else if (fair_cnt_q > good_cnt_q && fair_cnt_q > poor_cnt_q) begin
			verdict_d = kmc_pkg::VERDICT_FAIR;
		end else if (poor_cnt_q > good_cnt_q && poor_cnt_q > fair_cnt_q) begin
			verdict_d = kmc_pkg::VERDICT_POOR;
		end else begin
			verdict_d = kmc_pkg::VERDICT_NONE;
		end
	end

	// Sequencer, store count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			keff_q      <= '0;
			tally_q     <= '0;
			good_cnt_q  <= '0;
			fair_cnt_q  <= '0;
			poor_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			verdict_q   <= kmc_pkg::VERDICT_NONE;
			good_out_q  <= '0;
			fair_out_q  <= '0;
			poor_out_q  <= '0;
		end else begin
			rd_vld_s1 <= issue;
			// S_DONE reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (command)
							kmc_pkg::CMD_CLEAR: count_q <= '0;
							kmc_pkg::CMD_ADD: begin
								if (!store_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							kmc_pkg::CMD_QUERY: begin
								keff_q     <= keff_d;
								rd_idx_q   <= '0;
								tally_q    <= '0;
								good_cnt_q <= '0;
								fair_cnt_q <= '0;
								poor_cnt_q <= '0;
								state_q    <= S_READ;
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end else if (!rd_vld_s1 && !vld_s2) begin
						state_q <= S_TALLY;
					end
				end
				S_TALLY: begin
					if (tally_q < keff_q) begin
						tally_q <= tally_q + VW'(1);
						case (slot_label)
							kmc_pkg::LBL_GOOD: good_cnt_q <= good_cnt_q + VW'(1);
							kmc_pkg::LBL_FAIR: fair_cnt_q <= fair_cnt_q + VW'(1);
							default:           poor_cnt_q <= poor_cnt_q + VW'(1);
						endcase
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						verdict_q   <= verdict_d;
						good_out_q  <= good_cnt_q;
						fair_out_q  <= fair_cnt_q;
						poor_out_q  <= poor_cnt_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Query scores held for the whole read pass
	always_ff @(posedge clk) begin
		if (is_query) begin
			q0_q <= score_first;
			q1_q <= score_second;
			q2_q <= score_third;
		end
	end

	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign good_votes = good_out_q;
	assign fair_votes = fair_out_q;
	assign poor_votes = poor_out_q;

	// The store never holds more references than it has entries
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REFS))
		else $error("reference count above store depth");

	// No new item is taken while RAM reads are still in flight
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!rd_vld_s1 && !vld_s2))
		else $error("input accepted with distance pipeline busy");

	// A good verdict always carries a strict majority of good votes
	a_good_majority: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == kmc_pkg::VERDICT_GOOD) |->
		(good_out_q > fair_out_q && good_out_q > poor_out_q))
		else $error("good verdict without strict majority");

	// The tally never runs past the effective K
	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TALLY) |-> (tally_q <= keff_q))
		else $error("tally index past effective K");

endmodule

[verif/tb_knn_manhattan_classifier.sv]
// Testbench for knn_manhattan_classifier: queued stimulus, scoreboard against an in-bench vote model.
`timescale 1ns / 100ps

module tb_knn_manhattan_classifier;

	localparam int STORE_DEPTH   = 16;
	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_ITEMS   = 220;
	localparam int NUM_PHASES    = 8;
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] s1;
		logic [6:0] s2;
		logic [6:0] s3;
	} score_item_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [4:0] good;
		logic [4:0] fair;
		logic [4:0] poor;
	} vote_t;

	// DUT signals
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] command = '0;
	logic [6:0] score_first = '0;
	logic [6:0] score_second = '0;
	logic [6:0] score_third = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] verdict;
	logic [4:0] good_votes;
	logic [4:0] fair_votes;
	logic [4:0] poor_votes;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	// Shadow copy of the block's state and registers
	logic [6:0] ref_scores [STORE_DEPTH][3];
	int         ref_count = 0;
	logic [4:0] k_cfg = kmc_pkg::K_RESET;
	logic [6:0] good_thr = kmc_pkg::GOOD_THR_RESET;
	logic [6:0] fair_thr = kmc_pkg::FAIR_THR_RESET;

	// Stimulus and scoreboard bookkeeping
	score_item_t pending_items [$];
	vote_t       expected_votes [$];
	score_item_t cur_item;
	vote_t       head_vote;
	int          pushed_count = 0;
	int          accepted_count = 0;
	int          counted_items = 0;
	int          errors = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_at = 0;
	int          hold_left = 0;
	logic        hold_fired = 1'b0;
	logic        in_taken = 1'b0;

	knn_manhattan_classifier #(.MAX_REFS(STORE_DEPTH)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.score_first  (score_first),
		.score_second (score_second),
		.score_third  (score_third),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.verdict      (verdict),
		.good_votes   (good_votes),
		.fair_votes   (fair_votes),
		.poor_votes   (poor_votes),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Label of a stored reference by the floor mean of its scores
	function automatic int label_of(input int idx);
		int mean;
		mean = (int'(ref_scores[idx][0]) + int'(ref_scores[idx][1])
			+ int'(ref_scores[idx][2])) / 3;
		if (mean > int'(good_thr))
			return int'(kmc_pkg::LBL_GOOD);
		if (mean > int'(fair_thr))
			return int'(kmc_pkg::LBL_FAIR);
		return int'(kmc_pkg::LBL_POOR);
	endfunction

	function automatic int abs_diff(input logic [6:0] a, input logic [6:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	// K nearest by Manhattan distance, ties broken by load order, then majority vote
	function automatic vote_t tally_neighbors(input score_item_t q);
		int    distance [STORE_DEPTH];
		int    cnt [3];
		int    keff;
		int    rank;
		vote_t v;
		cnt = '{0, 0, 0};
		keff = (int'(k_cfg) < ref_count) ? int'(k_cfg) : ref_count;
		for (int i = 0; i < ref_count; i++)
			distance[i] = abs_diff(q.s1, ref_scores[i][0])
				+ abs_diff(q.s2, ref_scores[i][1]) + abs_diff(q.s3, ref_scores[i][2]);
		for (int i = 0; i < ref_count; i++) begin
			rank = 0;
			for (int j = 0; j < ref_count; j++)
				if (distance[j] < distance[i] || (distance[j] == distance[i] && j < i))
					rank++;
			if (rank < keff)
				cnt[label_of(i)]++;
		end
		v.good = 5'(cnt[kmc_pkg::LBL_GOOD]);
		v.fair = 5'(cnt[kmc_pkg::LBL_FAIR]);
		v.poor = 5'(cnt[kmc_pkg::LBL_POOR]);
		if (cnt[kmc_pkg::LBL_GOOD] > cnt[kmc_pkg::LBL_FAIR]
				&& cnt[kmc_pkg::LBL_GOOD] > cnt[kmc_pkg::LBL_POOR])
			v.verdict = kmc_pkg::VERDICT_GOOD;
		else if (cnt[kmc_pkg::LBL_FAIR] > cnt[kmc_pkg::LBL_GOOD]
				&& cnt[kmc_pkg::LBL_FAIR] > cnt[kmc_pkg::LBL_POOR])
			v.verdict = kmc_pkg::VERDICT_FAIR;
		else if (cnt[kmc_pkg::LBL_POOR] > cnt[kmc_pkg::LBL_GOOD]
				&& cnt[kmc_pkg::LBL_POOR] > cnt[kmc_pkg::LBL_FAIR])
			v.verdict = kmc_pkg::VERDICT_POOR;
		else
			v.verdict = kmc_pkg::VERDICT_NONE;
		return v;
	endfunction

	// Update shadow state for one accepted transaction
	task automatic apply_item(input score_item_t it);
		case (it.cmd)
			kmc_pkg::CMD_CLEAR: ref_count = 0;
			kmc_pkg::CMD_ADD: begin
				if (ref_count < STORE_DEPTH) begin
					ref_scores[ref_count][0] = it.s1;
					ref_scores[ref_count][1] = it.s2;
					ref_scores[ref_count][2] = it.s3;
					ref_count++;
				end
			end
			kmc_pkg::CMD_QUERY: expected_votes.push_back(tally_neighbors(it));
			default: ;
		endcase
	endtask

	// Input driver
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_item = pending_items.pop_front();
				in_valid     <= 1'b1;
				command      <= cur_item.cmd;
				score_first  <= cur_item.s1;
				score_second <= cur_item.s2;
				score_third  <= cur_item.s3;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output ready: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_fired && hold_at != 0 && accepted_count >= hold_at) begin
			hold_fired <= 1'b1;
			hold_left  <= LONG_HOLD;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: input acceptance and result checking
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			accepted_count++;
			apply_item('{command, score_first, score_second, score_third});
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_votes.size() == 0) begin
				$error("unexpected result: verdict %0d votes %0d/%0d/%0d",
					verdict, good_votes, fair_votes, poor_votes);
				errors++;
			end else begin
				head_vote = expected_votes.pop_front();
				if (verdict !== head_vote.verdict) begin
					$error("verdict: expected %0d, actual %0d", head_vote.verdict, verdict);
					errors++;
				end
				if (good_votes !== head_vote.good) begin
					$error("good_votes: expected %0d, actual %0d", head_vote.good, good_votes);
					errors++;
				end
				if (fair_votes !== head_vote.fair) begin
					$error("fair_votes: expected %0d, actual %0d", head_vote.fair, fair_votes);
					errors++;
				end
				if (poor_votes !== head_vote.poor) begin
					$error("poor_votes: expected %0d, actual %0d", head_vote.poor, poor_votes);
					errors++;
				end
			end
		end
	end

	task automatic queue_item(input logic [1:0] cmd, input int a, input int b, input int c);
		pending_items.push_back('{cmd, 7'(a), 7'(b), 7'(c)});
		pushed_count++;
		if (cmd != CMD_IGNORED)
			counted_items++;
	endtask

	function automatic int score_near(input int center, input int spread);
		int v;
		v = center + $urandom_range(2 * spread) - spread;
		return (v < 0) ? 0 : (v > 127) ? 127 : v;
	endfunction

	// Well-formed sequence: clear (usually), a few adds, a few queries
	task automatic queue_burst();
		int center;
		int spread;
		int n_add;
		int n_query;
		center = $urandom_range(127);
		case ($urandom_range(3))
			0: spread = 0;
			1: spread = 3;
			2: spread = 12;
			default: spread = 127;
		endcase
		if ($urandom_range(4) != 0)
			queue_item(kmc_pkg::CMD_CLEAR, $urandom_range(127), $urandom_range(127),
				$urandom_range(127));
		n_add = $urandom_range(20);
		n_query = $urandom_range(1, 6);
		for (int i = 0; i < n_add; i++)
			queue_item(kmc_pkg::CMD_ADD, score_near(center, spread), score_near(center, spread),
				score_near(center, spread));
		for (int i = 0; i < n_query; i++)
			if ($urandom_range(3) == 0)
				queue_item(kmc_pkg::CMD_QUERY, $urandom_range(127), $urandom_range(127),
					$urandom_range(127));
			else
				queue_item(kmc_pkg::CMD_QUERY, score_near(center, spread),
					score_near(center, spread), score_near(center, spread));
	endtask

	// Wait until every transaction is in and every result is out, then let the block settle
	task automatic wait_drained();
		while (accepted_count != pushed_count || expected_votes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			kmc_pkg::CFG_K_NEIGHBORS:    k_cfg = data[4:0];
			kmc_pkg::CFG_GOOD_THRESHOLD: good_thr = data;
			kmc_pkg::CFG_FAIR_THRESHOLD: fair_thr = data;
			default: ;
		endcase
	endtask

	// Main sequence
	initial begin
		int k_tab [NUM_PHASES];
		int good_tab [NUM_PHASES];
		int fair_tab [NUM_PHASES];
		int send_tab [NUM_PHASES];
		int stall_tab [NUM_PHASES];
		int phase_start;
		int kv;
		k_tab     = '{1, 16, 31, 0, 2, -1, 4, -1};
		good_tab  = '{127, 0, 70, 64, 40, -1, -1, -1};
		fair_tab  = '{0, 0, 60, 64, 90, -1, -1, -1};
		send_tab  = '{0, 49, 0, 19, 0, 49, 0, 19};
		stall_tab = '{0, 0, 49, 19, 0, 0, 49, 19};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part at reset configuration
		queue_item(kmc_pkg::CMD_QUERY, 10, 20, 30);
		queue_item(CMD_IGNORED, 127, 127, 127);
		queue_item(kmc_pkg::CMD_CLEAR, 0, 0, 0);
		queue_item(kmc_pkg::CMD_ADD, 0, 0, 0);
		queue_item(kmc_pkg::CMD_ADD, 127, 127, 127);
		queue_item(kmc_pkg::CMD_ADD, 71, 71, 71);
		queue_item(kmc_pkg::CMD_ADD, 70, 70, 70);
		queue_item(kmc_pkg::CMD_ADD, 61, 61, 61);
		queue_item(kmc_pkg::CMD_ADD, 60, 60, 60);
		queue_item(kmc_pkg::CMD_ADD, 72, 71, 70);
		queue_item(kmc_pkg::CMD_ADD, 127, 0, 127);
		queue_item(kmc_pkg::CMD_QUERY, 0, 0, 0);
		queue_item(kmc_pkg::CMD_QUERY, 127, 127, 127);
		queue_item(kmc_pkg::CMD_QUERY, 70, 70, 70);
		// Fill past capacity; the last add is dropped
		for (int i = 0; i < 9; i++)
			queue_item(kmc_pkg::CMD_ADD, i * 15, 127 - i * 15, i * 7);
		queue_item(kmc_pkg::CMD_QUERY, 65, 65, 65);
		queue_item(kmc_pkg::CMD_CLEAR, 127, 127, 127);

		// Random phases, each with its own register setting and idling mix
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			kv = (k_tab[p] < 0) ? $urandom_range(31) : k_tab[p];
			write_reg(kmc_pkg::CFG_K_NEIGHBORS, {2'($urandom_range(3)), 5'(kv)});
			write_reg(kmc_pkg::CFG_GOOD_THRESHOLD,
				(good_tab[p] < 0) ? 7'($urandom_range(127)) : 7'(good_tab[p]));
			write_reg(kmc_pkg::CFG_FAIR_THRESHOLD,
				(fair_tab[p] < 0) ? 7'($urandom_range(127)) : 7'(fair_tab[p]));
			send_idle_pct = send_tab[p];
			stall_pct = stall_tab[p];
			if (p == 2)
				hold_at = accepted_count + 40;
			phase_start = counted_items;
			while (counted_items - phase_start < PHASE_ITEMS)
				if ($urandom_range(9) == 0)
					queue_item(2'($urandom_range(3)), $urandom_range(127), $urandom_range(127),
						$urandom_range(127));
				else
					queue_burst();
		end

		wait_drained();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
rtl/kmc_pkg.sv
rtl/kmc_ram.sv
rtl/kmc_nbr_list.sv
rtl/knn_manhattan_classifier.sv
verif/tb_knn_manhattan_classifier.sv
